// ----- design/mcc_pkg.sv -----
// Package for the minimum coin change block: field widths, register indexes,
// register reset values and the command bundle sent to the table unit.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps
`default_nettype none

package mcc_pkg;

    // Widths of the fixed fields.
    localparam int SUM_W      = 10;  // target sum
    localparam int CNT_W      = 11;  // table entry and coin count result
    localparam int COIN_W     = 10;  // one denomination
    localparam int CCOUNT_W   = 3;   // coin_count register
    localparam int CFG_IDX_W  = 3;   // configuration register index
    localparam int COIN_REGS  = 6;   // number of denomination registers

    // Parameter defaults.
    localparam int DEF_MAX_SUM   = 1023;
    localparam int DEF_MAX_COINS = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_LAST  = 3'd6;

    // Register values after reset.
    localparam logic [CCOUNT_W-1:0] RST_COIN_COUNT = 3'd3;
    localparam logic [COIN_W-1:0]   RST_COIN_0     = 10'd1;
    localparam logic [COIN_W-1:0]   RST_COIN_1     = 10'd2;
    localparam logic [COIN_W-1:0]   RST_COIN_2     = 10'd5;
    localparam logic [COIN_W-1:0]   RST_COIN_REST  = 10'd1;

    // Commands from the sequencer to the table unit; at most one is set.
    typedef struct packed {
        logic init_wr;   // write the initial value at the current address
        logic relax_rd;  // read current and previous entries for relaxation
        logic final_rd;  // read the answer entry through the previous port
    } t_tbl_cmd;

endpackage : mcc_pkg

`default_nettype wire

// ----- design/mcc_table.sv -----
// Table unit of the minimum coin change block: the scratch table memory with
// two registered read ports, write forwarding and the relaxation stage.
// Depends on mcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcc_table #(
    parameter int MAX_SUM = mcc_pkg::DEF_MAX_SUM,
    parameter int AW      = $clog2(MAX_SUM + 1)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire mcc_pkg::t_tbl_cmd       i_cmd,
    input  wire [AW-1:0]                 i_cur_addr,
    input  wire [AW-1:0]                 i_prev_addr,
    input  wire [mcc_pkg::CNT_W-1:0]     i_init_data,
    output logic [mcc_pkg::CNT_W-1:0]    o_result
);
    import mcc_pkg::*;

    localparam int Depth = MAX_SUM + 1;

    logic [CNT_W-1:0] mem [Depth];

    // Registered read data and forwarding information.
    logic [CNT_W-1:0] r_rd_cur;
    logic [CNT_W-1:0] r_rd_prev;
    logic [CNT_W-1:0] r_fwd_val;
    logic             r_fwd_cur;
    logic             r_fwd_prev;

    // Relaxation stage: the entry whose reads are now available.
    logic             r_st_valid;
    logic [AW-1:0]    r_st_addr;

    logic             rd_en;
    logic             we;
    logic [AW-1:0]    wa;
    logic [CNT_W-1:0] wd;
    logic [CNT_W-1:0] cur_eff;
    logic [CNT_W-1:0] prev_eff;
    logic [CNT_W:0]   cand;
    logic [CNT_W-1:0] relax_val;

    assign rd_en = i_cmd.relax_rd | i_cmd.final_rd;

    // A write in the same cycle as a read is not seen by the read; take it
    // from the forwarding register instead.
    assign cur_eff  = r_fwd_cur  ? r_fwd_val : r_rd_cur;
    assign prev_eff = r_fwd_prev ? r_fwd_val : r_rd_prev;

    // Relaxation: keep the smaller of the entry and the shorter path plus one.
    assign cand      = {1'b0, prev_eff} + {{CNT_W{1'b0}}, 1'b1};
    assign relax_val = (cand < {1'b0, cur_eff}) ? cand[CNT_W-1:0] : cur_eff;

    // Single write port, shared by initialization and relaxation.
    always_comb begin
        if (r_st_valid) begin
            we = 1'b1;
            wa = r_st_addr;
            wd = relax_val;
        end else begin
            we = i_cmd.init_wr;
            wa = i_cur_addr;
            wd = i_init_data;
        end
    end

    // Memory and its registered read ports.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_cur   <= mem[i_cur_addr];
            r_rd_prev  <= mem[i_prev_addr];
            r_fwd_cur  <= we && (wa == i_cur_addr);
            r_fwd_prev <= we && (wa == i_prev_addr);
            r_fwd_val  <= wd;
        end
    end

    // Stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_valid <= 1'b0;
        end else begin
            r_st_valid <= i_cmd.relax_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.relax_rd) begin
            r_st_addr <= i_cur_addr;
        end
    end

    assign o_result = prev_eff;

    // Initialization and relaxation never compete for the write port.
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.init_wr && r_st_valid))
        else $error("initial write collides with relaxation write");

    // The answer is never read while a relaxation read is in flight.
    a_final_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.final_rd |-> !r_st_valid && !i_cmd.relax_rd)
        else $error("answer read before relaxation drained");

    // Every relaxation read is followed by its write-back.
    a_stage_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.relax_rd |=> r_st_valid && (r_st_addr == $past(i_cur_addr)))
        else $error("relaxation stage lost an entry");

    // Relaxation never raises an entry.
    a_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st_valid |-> relax_val <= cur_eff)
        else $error("relaxation raised an entry");

endmodule : mcc_table

`default_nettype wire

// ----- design/min_coin_change.sv -----
// Top level of the minimum coin change block: configuration registers,
// query sequencer and result register. Depends on mcc_pkg and mcc_table.
//
//   Channel  | Direction | Handshake                   | Payload
//   ---------+-----------+-----------------------------+-----------------------------
//   input    | in        | i_in_valid / o_in_ready     | i_target_sum
//   result   | out       | o_out_valid / i_out_ready   | o_min_coins, o_unreachable
//   config   | in        | i_cfg_wr_en (no wait)       | i_cfg_index, i_cfg_wdata
//
// One query of sum S first writes the table entries 0..S, then for each
// active coin 0<d<=S relaxes entries d..S, skipping coins that are zero or
// above S; the single write port of the table, one entry per cycle, sets the
// pace of both passes.
// Reset is synchronous and active low; the table itself is not cleared.
// A result waits in its output register; a finished query stalls there only
// while an earlier result has not been taken. A new query is taken when idle.
`timescale 1ns / 1ps
`default_nettype none

module min_coin_change #(
    parameter int MAX_SUM   = mcc_pkg::DEF_MAX_SUM,
    parameter int MAX_COINS = mcc_pkg::DEF_MAX_COINS
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_wr_en,
    input  wire [mcc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [mcc_pkg::COIN_W-1:0]      i_cfg_wdata,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire [mcc_pkg::SUM_W-1:0]       i_target_sum,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [mcc_pkg::CNT_W-1:0]      o_min_coins,
    output logic                           o_unreachable
);
    import mcc_pkg::*;

    localparam int AW = $clog2(MAX_SUM + 1);
    localparam logic [16:0]         MaxSumW   = 17'(MAX_SUM);
    localparam logic [CCOUNT_W-1:0] MaxCoinsW = CCOUNT_W'(MAX_COINS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_COIN,
        S_RELAX,
        S_FINAL,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [CCOUNT_W-1:0] r_coin_count;
    logic [COIN_W-1:0]   r_coin_val [COIN_REGS];
    logic [SUM_W-1:0]    r_s;
    logic [CNT_W-1:0]    r_i;
    logic [COIN_W-1:0]   r_d;
    logic [CCOUNT_W-1:0] r_coin;
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_min_coins;
    logic                r_unreachable;

    t_tbl_cmd            tbl_cmd;
    logic [AW-1:0]       cur_addr;
    logic [AW-1:0]       prev_addr;
    logic [CNT_W-1:0]    init_data;
    logic [CNT_W-1:0]    tbl_result;
    logic [CNT_W-1:0]    s_inf;
    logic [SUM_W-1:0]    sat_sum;
    logic [CCOUNT_W-1:0] n_eff;
    logic [COIN_W-1:0]   coin_d;

    // Map a count onto a table address.
    function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] v);
        logic [16:0] w;
        w = 17'(v);
        return w[AW-1:0];
    endfunction

    assign sat_sum = (17'(i_target_sum) > MaxSumW) ? MaxSumW[SUM_W-1:0] : i_target_sum;
    assign n_eff   = (r_coin_count > MaxCoinsW) ? MaxCoinsW : r_coin_count;
    assign s_inf   = {1'b0, r_s} + {{(CNT_W-1){1'b0}}, 1'b1};
    assign coin_d  = r_coin_val[r_coin];

    // Commands and addresses for the table unit.
    always_comb begin
        tbl_cmd.init_wr  = (r_state == S_INIT);
        tbl_cmd.relax_rd = (r_state == S_RELAX);
        tbl_cmd.final_rd = (r_state == S_FINAL);
        cur_addr  = to_addr(r_i);
        prev_addr = (r_state == S_FINAL) ? to_addr({1'b0, r_s})
                                         : to_addr(r_i - {1'b0, r_d});
        init_data = (r_i == '0) ? '0 : s_inf;
    end

    mcc_table #(
        .MAX_SUM (MAX_SUM),
        .AW      (AW)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (tbl_cmd),
        .i_cur_addr  (cur_addr),
        .i_prev_addr (prev_addr),
        .i_init_data (init_data),
        .o_result    (tbl_result)
    );

    // Sequencer, configuration registers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_coin_count  <= RST_COIN_COUNT;
            r_coin_val[0] <= RST_COIN_0;
            r_coin_val[1] <= RST_COIN_1;
            r_coin_val[2] <= RST_COIN_2;
            r_coin_val[3] <= RST_COIN_REST;
            r_coin_val[4] <= RST_COIN_REST;
            r_coin_val[5] <= RST_COIN_REST;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_COIN_COUNT) begin
                    r_coin_count <= i_cfg_wdata[CCOUNT_W-1:0];
                end else if (i_cfg_index >= CFG_COIN_FIRST && i_cfg_index <= CFG_COIN_LAST) begin
                    r_coin_val[i_cfg_index - CFG_COIN_FIRST] <= i_cfg_wdata;
                end
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_s     <= sat_sum;
                        r_i     <= '0;
                        r_coin  <= '0;
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    if (r_i == {1'b0, r_s}) begin
                        r_state <= S_COIN;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_COIN: begin
                    // A zero coin or one above the sum changes no entry.
                    if (r_coin == n_eff) begin
                        r_state <= S_FINAL;
                    end else if (coin_d == '0 || coin_d > r_s) begin
                        r_coin <= r_coin + 1'b1;
                    end else begin
                        r_d     <= coin_d;
                        r_i     <= {1'b0, coin_d};
                        r_state <= S_RELAX;
                    end
                end
                S_RELAX: begin
                    if (r_i == {1'b0, r_s}) begin
                        r_coin  <= r_coin + 1'b1;
                        r_state <= S_COIN;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_FINAL: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_min_coins   <= tbl_result;
                        r_unreachable <= (tbl_result == s_inf);
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_min_coins   = r_min_coins;
    assign o_unreachable = r_unreachable;

endmodule : min_coin_change

`default_nettype wire
